@@ sv/pdl_pkg.sv @@
// ----------------------------------------------------------------------------
// pdl_pkg
// Shared types and constants of the positional deque list: capacity, field
// widths, operation and status codes, and the control structs.
// ----------------------------------------------------------------------------
package pdl_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int ECOUNT_W = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    // wide enough for the count plus one and for any position
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_INSERT_POS = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_POP_BACK   = 3'd4,
        MODE_REMOVE_POS = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] idx;
        t_status          status;
    } t_op_ctl;

    typedef struct packed {
        logic take_left;
        logic take_new;
        logic take_right;
    } t_cell_ctl;

endpackage

@@ sv/pdl_cell.sv @@
// ----------------------------------------------------------------------------
// pdl_cell
// One list slot: holds a value, loads from its left neighbor on an insert
// below it, from its right neighbor on a removal at or below it, or the new
// value when the insert lands on it.
// ----------------------------------------------------------------------------
module pdl_cell (
    input  logic                              i_clk,
    input  pdl_pkg::t_cell_ctl                i_ctl,
    input  logic signed [pdl_pkg::DATA_W-1:0] i_left,
    input  logic signed [pdl_pkg::DATA_W-1:0] i_right,
    input  logic signed [pdl_pkg::DATA_W-1:0] i_new,
    output logic signed [pdl_pkg::DATA_W-1:0] o_value
);

    logic signed [pdl_pkg::DATA_W-1:0] r_value;

    // the slot holds its value when no load is asked for
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_new) begin
            r_value <= i_new;
        end else if (i_ctl.take_left) begin
            r_value <= i_left;
        end else if (i_ctl.take_right) begin
            r_value <= i_right;
        end
    end

    assign o_value = r_value;

endmodule

@@ sv/pdl_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdl_ctrl
// Element counter and operation decode: checks full, empty and position,
// and gives the slot index where the chain opens or closes a gap.
// ----------------------------------------------------------------------------
module pdl_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [pdl_pkg::MODE_W-1:0]   i_mode,
    input  logic [pdl_pkg::POS_W-1:0]    i_pos,
    output pdl_pkg::t_op_ctl             o_op,
    output logic [pdl_pkg::CNT_W-1:0]    o_count_next
);

    logic [pdl_pkg::CNT_W-1:0] r_count;
    logic [pdl_pkg::CNT_W-1:0] n_count;
    logic [pdl_pkg::CMP_W-1:0] pos_x;
    logic [pdl_pkg::CMP_W-1:0] cnt_x;
    logic                      full;
    logic                      empty;

    assign pos_x = pdl_pkg::CMP_W'(i_pos);
    assign cnt_x = pdl_pkg::CMP_W'(r_count);
    assign full  = (r_count == pdl_pkg::CNT_W'(pdl_pkg::CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        o_op.ins    = 1'b0;
        o_op.rem    = 1'b0;
        o_op.idx    = '0;
        o_op.status = pdl_pkg::ST_OK;
        unique case (i_mode)
            pdl_pkg::MODE_PUSH_FRONT: begin
                if (full) begin
                    o_op.status = pdl_pkg::ST_FULL;
                end else begin
                    o_op.ins = 1'b1;
                end
            end
            pdl_pkg::MODE_PUSH_BACK: begin
                if (full) begin
                    o_op.status = pdl_pkg::ST_FULL;
                end else begin
                    o_op.ins = 1'b1;
                    o_op.idx = cnt_x[pdl_pkg::IDX_W-1:0];
                end
            end
            pdl_pkg::MODE_INSERT_POS: begin
                if (full) begin
                    o_op.status = pdl_pkg::ST_FULL;
                end else if (pos_x == '0 || pos_x > cnt_x + pdl_pkg::CMP_W'(1)) begin
                    o_op.status = pdl_pkg::ST_RANGE;
                end else begin
                    o_op.ins = 1'b1;
                    o_op.idx = pdl_pkg::IDX_W'(pos_x - pdl_pkg::CMP_W'(1));
                end
            end
            pdl_pkg::MODE_POP_FRONT: begin
                if (empty) begin
                    o_op.status = pdl_pkg::ST_EMPTY;
                end else begin
                    o_op.rem = 1'b1;
                end
            end
            pdl_pkg::MODE_POP_BACK: begin
                if (empty) begin
                    o_op.status = pdl_pkg::ST_EMPTY;
                end else begin
                    o_op.rem = 1'b1;
                    o_op.idx = pdl_pkg::IDX_W'(cnt_x - pdl_pkg::CMP_W'(1));
                end
            end
            pdl_pkg::MODE_REMOVE_POS: begin
                if (empty) begin
                    o_op.status = pdl_pkg::ST_EMPTY;
                end else if (pos_x == '0 || pos_x > cnt_x) begin
                    o_op.status = pdl_pkg::ST_RANGE;
                end else begin
                    o_op.rem = 1'b1;
                    o_op.idx = pdl_pkg::IDX_W'(pos_x - pdl_pkg::CMP_W'(1));
                end
            end
            // unused modes change nothing
            default: begin
                o_op.status = pdl_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        priority if (o_op.ins) begin
            n_count = r_count + pdl_pkg::CNT_W'(1);
        end else if (o_op.rem) begin
            n_count = r_count - pdl_pkg::CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    assign o_count_next = n_count;

endmodule

@@ sv/positional_deque_list_top.sv @@
// ----------------------------------------------------------------------------
// positional_deque_list_top
// Bounded ordered list of signed 32-bit values with push, pop, insert and
// remove at either end or at a 1-based position, built as a row of cells.
// ----------------------------------------------------------------------------
//  channel   direction  tdata fields (lsb first)
//  s_axis    in         mode[2:0], item_value[34:3], position[39:35]
//  m_axis    out        status[1:0], removed_value[33:2], element_count[38:34]
//
//  every operation is applied at once: all cells shift in parallel and
//  the count register updates on the same edge, so one beat per cycle
//  enters while the result register is empty or being drained.
//  the result register holds one beat; a stalled output stalls the input.
//  reset (synchronous, active low) empties the list; cell contents are
//  not cleared and are never read beyond the count.
// ----------------------------------------------------------------------------
module positional_deque_list_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // mode, item_value, position
    input  logic [pdl_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // status, removed_value, element_count, one zero pad bit
    output logic [pdl_pkg::OUT_W-1:0]   o_m_axis_tdata
);

    localparam int N = pdl_pkg::CAPACITY;

    logic                               fire;
    logic [pdl_pkg::MODE_W-1:0]         in_mode;
    logic signed [pdl_pkg::DATA_W-1:0]  in_value;
    logic [pdl_pkg::POS_W-1:0]          in_pos;
    pdl_pkg::t_op_ctl                   op;
    logic [pdl_pkg::CNT_W-1:0]          count_next;
    logic [pdl_pkg::CMP_W-1:0]          count_wide;
    pdl_pkg::t_cell_ctl                 cell_ctl [N];
    logic signed [pdl_pkg::DATA_W-1:0]  cell_val [N];
    logic signed [pdl_pkg::DATA_W-1:0]  removed;

    logic                               r_out_valid;
    pdl_pkg::t_status                   r_status;
    logic signed [pdl_pkg::DATA_W-1:0]  r_removed;
    logic [pdl_pkg::ECOUNT_W-1:0]       r_ecount;

    assign in_mode  = i_s_axis_tdata[2:0];
    assign in_value = i_s_axis_tdata[34:3];
    assign in_pos   = i_s_axis_tdata[39:35];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign fire            = i_s_axis_tvalid && o_s_axis_tready;

    pdl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_mode       (in_mode),
        .i_pos        (in_pos),
        .o_op         (op),
        .o_count_next (count_next)
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic signed [pdl_pkg::DATA_W-1:0] left_val;
        logic signed [pdl_pkg::DATA_W-1:0] right_val;

        if (i == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = cell_val[i-1];
        end
        if (i == N - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_mid_r
            assign right_val = cell_val[i+1];
        end

        // insert opens a gap at idx, remove closes the gap at idx
        assign cell_ctl[i].take_new   = fire && op.ins &&
                                        (pdl_pkg::IDX_W'(i) == op.idx);
        assign cell_ctl[i].take_left  = fire && op.ins &&
                                        (pdl_pkg::IDX_W'(i) > op.idx);
        assign cell_ctl[i].take_right = fire && op.rem &&
                                        (pdl_pkg::IDX_W'(i) >= op.idx);

        pdl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[i]),
            .i_left  (left_val),
            .i_right (right_val),
            .i_new   (in_value),
            .o_value (cell_val[i])
        );
    end

    // value leaving the list: or of the cell picked by the index
    always_comb begin
        removed = '0;
        for (int i = 0; i < N; i++) begin
            if (op.rem && pdl_pkg::IDX_W'(i) == op.idx) begin
                removed = removed | cell_val[i];
            end
        end
    end

    assign count_wide = pdl_pkg::CMP_W'(count_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status  <= op.status;
            r_removed <= removed;
            r_ecount  <= count_wide[pdl_pkg::ECOUNT_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_ecount, r_removed, r_status};

endmodule
